// ===== design/smrf_pkg.sv =====
// Package for the spike matmul reuse forest block: commands, sizes, states.
package smrf_pkg;

  localparam int BLOCK_ROWS_D  = 256;
  localparam int K_BLOCK_D     = 16;
  localparam int COLS_D        = 16;
  localparam int WEIGHT_ROWS_D = 1024;
  localparam int PERM_DEPTH    = 1024;

  typedef enum logic [1:0] {
    CMD_LOAD_W = 2'd0,
    CMD_LOAD_P = 2'd1,
    CMD_STEP   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_COPY_RD,
    ST_COPY_WB,
    ST_PERM_RD,
    ST_PERM_WT,
    ST_ADD,
    ST_ACC_RD,
    ST_ACC_WB,
    ST_RD_RD,
    ST_RD_OUT
  } state_t;

endpackage

// ===== design/spike_matmul_reuse_forest.sv =====
// Top level: binary-activation by integer-weight matrix product with partial-sum reuse.
//
// Usage notes
//   Input channel in_*: one request carries a command. Load weight writes one
//   64-bit lane of a weight row and load permutation writes one entry. A plan step
//   for a row copies the parent's local vector (or zero), adds the permuted
//   weight rows selected by the residual bits, stores the local vector and
//   adds it into the row accumulator. A read emits COLS results on out_*
//   (out_last on the final column) and clears the row accumulator.
//   Weight, local and accumulator memories hold COLS elements per row side by
//   side (one wide word per row), so all columns are worked by COLS parallel adders.
//   Plan step: a copy (ST_COPY_RD, ST_COPY_WB), then a walk of the residual bits
//   in ST_PERM_RD: a clear bit is skipped there, a set bit goes through ST_PERM_RD,
//   ST_PERM_WT and ST_ADD (perm read, weight read, add); ST_PERM_RD leaves the walk,
//   then ST_ACC_RD and ST_ACC_WB accumulate. The serial walk of the 16 residual bits
//   through the single permutation and weight ports sets the length of a step.
//   Read: ST_RD_RD, then one result per accepted output cycle in ST_RD_OUT; stalls
//   on out_ready simply hold the result. Reset: a clearing pass over all BLOCK_ROWS
//   rows zeroes the accumulator memory; in_ready stays low during it.
//   The block takes one request at a time; in_ready is high only when idle.
module spike_matmul_reuse_forest #(
  parameter int BLOCK_ROWS  = smrf_pkg::BLOCK_ROWS_D,
  parameter int K_BLOCK     = smrf_pkg::K_BLOCK_D,
  parameter int COLS        = smrf_pkg::COLS_D,
  parameter int WEIGHT_ROWS = smrf_pkg::WEIGHT_ROWS_D
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_row,
  input  logic               in_has_parent,
  input  logic [7:0]         in_parent,
  input  logic [15:0]        in_residual,
  input  logic [9:0]         in_block_base,
  input  logic [9:0]         in_weight_row,
  input  logic [3:0]         in_column,
  input  logic signed [63:0] in_weight_value,
  input  logic [9:0]         in_perm_index,
  input  logic [9:0]         in_perm_target,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_row,
  output logic [3:0]         out_column,
  output logic signed [63:0] out_sum,
  output logic               out_last
);
  import smrf_pkg::*;

  localparam int RW  = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
  localparam int WW  = (WEIGHT_ROWS > 1) ? $clog2(WEIGHT_ROWS) : 1;
  localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int KW  = $clog2(K_BLOCK + 1);
  localparam int VW  = 64 * COLS;

  typedef logic [VW-1:0] vec_t;

  // memories: one wide word per row
  vec_t        wmem   [WEIGHT_ROWS];
  logic [9:0]  pmem   [PERM_DEPTH];
  vec_t        lmem   [BLOCK_ROWS];
  vec_t        amem   [BLOCK_ROWS];

  state_t state_r, state_nxt;
  logic [RW-1:0] row_r, par_r;
  logic          use_par_r;
  logic [15:0]   res_r;
  logic [9:0]    base_r;
  logic [KW-1:0] bit_r;
  logic [CW:0]   col_r;
  logic [RW:0]   clr_r;
  vec_t          vec_r;

  // memory read data and controls
  logic [9:0]  p_rd;
  vec_t        w_rd_vec;
  vec_t        l_rd, a_rd;
  logic [9:0]  p_addr;
  logic [WW-1:0] w_row;
  logic        a_we, l_we;
  logic [RW-1:0] a_addr_w, a_addr_r, l_addr_r;
  vec_t        a_wdata;

  assign w_row = WW'(p_rd);

  wire acc_in = in_valid && in_ready;

  // weight row read as one wide word; a load writes one 64-bit lane
  always_ff @(posedge clk) begin
    if (acc_in && cmd_t'(in_cmd) == CMD_LOAD_W && 32'(in_weight_row) < WEIGHT_ROWS
        && 32'(in_column) < COLS)
      wmem[WW'(in_weight_row)][CW'(in_column)*64 +: 64] <= in_weight_value;
    w_rd_vec <= wmem[w_row];
  end

  always_ff @(posedge clk) begin
    if (acc_in && cmd_t'(in_cmd) == CMD_LOAD_P)
      pmem[in_perm_index] <= in_perm_target;
    p_rd <= pmem[p_addr];
  end

  always_ff @(posedge clk) begin
    if (l_we)
      lmem[row_r] <= vec_r;
    l_rd <= lmem[l_addr_r];
  end

  always_ff @(posedge clk) begin
    if (a_we)
      amem[a_addr_w] <= a_wdata;
    a_rd <= amem[a_addr_r];
  end

  assign p_addr   = base_r + 10'(bit_r);
  assign l_addr_r = par_r;
  assign a_addr_r = row_r;

  wire cur_bit  = (bit_r < KW'(K_BLOCK)) && res_r[bit_r[3:0]];
  wire bits_end = (bit_r >= KW'(K_BLOCK));
  wire tgt_ok   = 32'(p_rd) < WEIGHT_ROWS;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (clr_r == (RW+1)'(BLOCK_ROWS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (acc_in && 32'(in_row) < BLOCK_ROWS) begin
          if (cmd_t'(in_cmd) == CMD_STEP)      state_nxt = ST_COPY_RD;
          else if (cmd_t'(in_cmd) == CMD_READ) state_nxt = ST_RD_RD;
        end
      end
      ST_COPY_RD: state_nxt = ST_COPY_WB;
      ST_COPY_WB: state_nxt = ST_PERM_RD;
      ST_PERM_RD: begin
        if (bits_end)     state_nxt = ST_ACC_RD;
        else if (cur_bit) state_nxt = ST_PERM_WT;
      end
      ST_PERM_WT: state_nxt = ST_ADD;
      ST_ADD:     state_nxt = ST_PERM_RD;
      ST_ACC_RD:  state_nxt = ST_ACC_WB;
      ST_ACC_WB:  state_nxt = ST_IDLE;
      ST_RD_RD:   state_nxt = ST_RD_OUT;
      ST_RD_OUT:  if (out_ready && col_r == (CW+1)'(COLS - 1)) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    a_we     = 1'b0;
    a_addr_w = row_r;
    a_wdata  = '0;
    l_we     = 1'b0;
    in_ready = (state_r == ST_IDLE);
    case (state_r)
      ST_CLEAR: begin
        a_we = 1'b1;
        a_addr_w = RW'(clr_r);
      end
      ST_ACC_WB: begin
        a_we = 1'b1;
        l_we = 1'b1;
        for (int c = 0; c < COLS; c++)
          a_wdata[c*64 +: 64] = a_rd[c*64 +: 64] + vec_r[c*64 +: 64];
      end
      ST_RD_OUT: begin
        a_we = out_ready && col_r == (CW+1)'(COLS - 1);
      end
      default: ;
    endcase
  end

  assign out_valid  = (state_r == ST_RD_OUT);
  assign out_row    = 8'(row_r);
  assign out_column = 4'(col_r);
  assign out_last   = (col_r == (CW+1)'(COLS - 1));
  assign out_sum    = a_rd[CW'(col_r)*64 +: 64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        row_r     <= RW'(in_row);
        par_r     <= RW'(in_parent);
        use_par_r <= in_has_parent && 32'(in_parent) < BLOCK_ROWS;
        res_r     <= in_residual;
        base_r    <= in_block_base;
        bit_r     <= '0;
        col_r     <= '0;
      end
      ST_COPY_WB: vec_r <= use_par_r ? l_rd : '0;
      ST_PERM_RD: if (!bits_end && !cur_bit) bit_r <= bit_r + 1'b1;
      ST_ADD: begin
        if (tgt_ok)
          for (int c = 0; c < COLS; c++)
            vec_r[c*64 +: 64] <= vec_r[c*64 +: 64] + w_rd_vec[c*64 +: 64];
        bit_r <= bit_r + 1'b1;
      end
      ST_RD_OUT: if (out_ready) col_r <= col_r + 1'b1;
      default: ;
    endcase
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while emitting");
  a_last_leave: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid) else $error("extra result");
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> (out_valid && out_column == $past(out_column) + 4'd1))
    else $error("column skipped");

endmodule
